>>> rtl/ncs_pkg.sv
// Package for the nested comment stripper: character codes, state and result types.
// Used by ncs_step and nested_comment_stripper; has no dependencies of its own.
package ncs_pkg;

  // deepest bracket comment nesting that is tracked
  localparam int unsigned DepthMax = 255;
  localparam int unsigned DepthW   = $clog2(DepthMax + 1);

  // character codes
  localparam logic [7:0] ChOpen   = 8'h5B;
  localparam logic [7:0] ChClose  = 8'h5D;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;

  // separator register value after reset
  localparam logic [7:0] SepReset = 8'd7;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLOSE = 2'd1,
    ERR_OVER  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_STRAY_CLOSE = 2'd1,
    STAT_OPEN       = 2'd2,
    STAT_OVERFLOW   = 2'd3
  } status_e;

  // scanner state carried from byte to byte
  typedef struct packed {
    quote_e              quote;
    logic [DepthW-1:0]   depth;
    logic                special;
    err_e                err;
  } scan_state_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       kept;
    logic       final_res;
    status_e    status;
  } result_t;

  localparam scan_state_t StateReset = '{
    quote:   QUOTE_NONE,
    depth:   '0,
    special: 1'b0,
    err:     ERR_NONE
  };

endpackage

>>> rtl/ncs_step.sv
// Per-byte update of the scanner: next state and result for one text byte.
// Depends on ncs_pkg for the character codes, state and result types.
module ncs_step (
  input  ncs_pkg::scan_state_t state_i,
  input  logic [7:0]           sep_code_i,
  input  logic [7:0]           cur_byte_i,
  input  logic [7:0]           next_byte_i,
  input  logic                 is_last_i,
  output ncs_pkg::scan_state_t state_o,
  output ncs_pkg::result_t     result_o
);

  ncs_pkg::scan_state_t upd;
  ncs_pkg::quote_e      qk;
  logic                 in_comm;
  logic                 keep;

  // quote class of the current byte
  always_comb begin
    case (cur_byte_i)
      ncs_pkg::ChSquote: qk = ncs_pkg::QUOTE_SINGLE;
      ncs_pkg::ChDquote: qk = ncs_pkg::QUOTE_DOUBLE;
      default:           qk = ncs_pkg::QUOTE_NONE;
    endcase
  end

  assign in_comm = (state_i.depth != '0) || state_i.special;

  // quote, bracket and error tracking
  always_comb begin
    upd  = state_i;
    keep = 1'b1;
    if (state_i.err != ncs_pkg::ERR_CLOSE) begin
      if (!in_comm && state_i.quote != ncs_pkg::QUOTE_NONE && qk == state_i.quote) begin
        upd.quote = ncs_pkg::QUOTE_NONE;
      end else if (state_i.quote == ncs_pkg::QUOTE_NONE && !in_comm &&
                   qk != ncs_pkg::QUOTE_NONE) begin
        upd.quote = qk;
      end else if (state_i.quote == ncs_pkg::QUOTE_NONE && cur_byte_i == ncs_pkg::ChOpen) begin
        if (next_byte_i == ncs_pkg::ChAmp && !in_comm) begin
          upd.special = 1'b1;
        end else if (state_i.depth >= ncs_pkg::DepthW'(ncs_pkg::DepthMax)) begin
          upd.depth = ncs_pkg::DepthW'(ncs_pkg::DepthMax);
          upd.err   = ncs_pkg::ERR_OVER;
        end else begin
          upd.depth = state_i.depth + ncs_pkg::DepthW'(1);
        end
      end else if (state_i.quote == ncs_pkg::QUOTE_NONE && cur_byte_i == ncs_pkg::ChClose) begin
        if (state_i.special) begin
          upd.special = 1'b0;
        end else if (state_i.depth == '0) begin
          upd.err = ncs_pkg::ERR_CLOSE;
          keep    = 1'b0;
        end else begin
          upd.depth = state_i.depth - ncs_pkg::DepthW'(1);
          keep      = 1'b0;
        end
      end
    end else begin
      keep = 1'b0;
    end
  end

  // kept byte with separator substitution
  always_comb begin
    result_o           = '0;
    result_o.final_res = is_last_i;
    result_o.status    = ncs_pkg::STAT_OK;
    if (keep && upd.depth == '0) begin
      result_o.kept = 1'b1;
      if (cur_byte_i == ncs_pkg::ChSemi && upd.quote == ncs_pkg::QUOTE_NONE && !upd.special) begin
        result_o.out_byte = sep_code_i;
      end else begin
        result_o.out_byte = cur_byte_i;
      end
    end
    if (is_last_i) begin
      if (upd.err == ncs_pkg::ERR_CLOSE) begin
        result_o.status = ncs_pkg::STAT_STRAY_CLOSE;
      end else if (upd.err == ncs_pkg::ERR_OVER) begin
        result_o.status = ncs_pkg::STAT_OVERFLOW;
      end else if (upd.depth != '0) begin
        result_o.status = ncs_pkg::STAT_OPEN;
      end
    end
  end

  // end of text returns the scanner to its reset state
  assign state_o = is_last_i ? ncs_pkg::StateReset : upd;

endmodule

>>> rtl/nested_comment_stripper.sv
// Top level of the nested comment stripper: input register, scanner state, result register.
// Depends on ncs_pkg and ncs_step.
//
//   channel   direction  handshake                 payload
//   ---------------------------------------------------------------------------------
//   input     in         in_valid_i / in_stall_o   cur_byte_i, next_byte_i, is_last_i
//   result    out        res_valid_o / res_stall_i out_byte_o, out_valid_o,
//                                                  final_res_o, status_o
//   separator in         sep_wr_en_i               sep_wr_data_i
//
// One request per cycle sustained while the result side does not stall; a byte taken is
// held in the input register, then loaded into the result register, which hands it on.
// The scanner state register is updated in the same cycle the byte moves from the
// input register to the result register, so each byte sees the state left by the last.
// Reset clears the scanner state and both valid flags and sets the separator to 7.
// A stall on the result side holds the result register and backs up into in_stall_o.
module nested_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sep_wr_en_i,
  input  logic [7:0] sep_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] cur_byte_i,
  input  logic [7:0] next_byte_i,
  input  logic       is_last_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       final_res_o,
  output logic [1:0] status_o
);

  logic                 in_valid_q;
  logic [7:0]           cur_q;
  logic [7:0]           next_q;
  logic                 last_q;
  logic [7:0]           sep_q;
  ncs_pkg::scan_state_t state_q;
  ncs_pkg::scan_state_t state_d;
  ncs_pkg::result_t     res_q;
  ncs_pkg::result_t     res_d;
  logic                 res_valid_q;
  logic                 advance;
  logic                 in_take;

  // pipeline control
  assign advance    = in_valid_q && (!res_valid_q || !res_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= ncs_pkg::SepReset;
    end else if (sep_wr_en_i) begin
      sep_q <= sep_wr_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cur_q  <= cur_byte_i;
      next_q <= next_byte_i;
      last_q <= is_last_i;
    end
  end

  // per-byte scanner logic
  ncs_step u_step (
    .state_i     (state_q),
    .sep_code_i  (sep_q),
    .cur_byte_i  (cur_q),
    .next_byte_i (next_q),
    .is_last_i   (last_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncs_pkg::StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_byte_o  = res_q.out_byte;
  assign out_valid_o = res_q.kept;
  assign final_res_o = res_q.final_res;
  assign status_o    = res_q.status;

  // a dropped byte carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("dropped byte with nonzero value");

  // only the last byte of a text reports a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ncs_pkg::STAT_OK |-> final_res_o)
    else $error("status on a byte that is not last");

  // end of text clears the scanner state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> state_q == ncs_pkg::StateReset)
    else $error("state not cleared after end of text");

  // a stray close stays until the end of the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err == ncs_pkg::ERR_CLOSE && !(advance && last_q)
      |=> state_q.err == ncs_pkg::ERR_CLOSE)
    else $error("stray close error lost");

  // depth saturates at its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.depth <= ncs_pkg::DepthW'(ncs_pkg::DepthMax))
    else $error("comment depth beyond limit");

endmodule

>>> verif/nested_comment_stripper_test.sv
// Testbench for nested_comment_stripper: directed text table, a depth-limit text, then
// random texts and noise, each result checked against the table or a cycle-free bench scanner.
// Depends on ncs_pkg and the nested_comment_stripper RTL.
module nested_comment_stripper_test;

  localparam int unsigned IdleLimit = 5000;
  localparam logic [7:0]  ChX       = 8'h78;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_BURSTY
  } stall_mode_e;

  // one directed request, with a typed result where it is obvious
  typedef struct packed {
    logic [7:0]       cur;
    logic [7:0]       nxt;
    logic             last;
    logic             typed;
    ncs_pkg::result_t want;
  } text_vec_t;

  localparam ncs_pkg::result_t NoWant = '{8'h00, 1'b0, 1'b0, ncs_pkg::STAT_OK};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       sep_wr_en_i = 1'b0;
  logic [7:0] sep_wr_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] cur_byte_i = 8'h00;
  logic [7:0] next_byte_i = 8'h00;
  logic       is_last_i = 1'b0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       final_res_o;
  logic [1:0] status_o;

  nested_comment_stripper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sep_wr_en_i  (sep_wr_en_i),
    .sep_wr_data_i(sep_wr_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cur_byte_i   (cur_byte_i),
    .next_byte_i  (next_byte_i),
    .is_last_i    (is_last_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .out_byte_o   (out_byte_o),
    .out_valid_o  (out_valid_o),
    .final_res_o  (final_res_o),
    .status_o     (status_o)
  );

  // clock, period 12
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scanner copy and separator as the bench sees them
  ncs_pkg::quote_e            quote_q = ncs_pkg::QUOTE_NONE;
  logic [ncs_pkg::DepthW-1:0] depth_q = '0;
  logic                       special_q = 1'b0;
  ncs_pkg::err_e              err_q = ncs_pkg::ERR_NONE;
  logic [7:0]                 sep_q = ncs_pkg::SepReset;

  ncs_pkg::result_t cleaned_q [$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned kept_seen = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned items_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic        gaps_on = 1'b1;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_span = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_run = 0;
  logic        stall_hold = 1'b0;

  // directed texts, separator at its reset value
  text_vec_t dir_tab [30] = '{
    // plain text then separator at end of text
    '{8'h61, ncs_pkg::ChSemi, 1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, ncs_pkg::STAT_OK}},
    '{ncs_pkg::ChSemi, 8'h00, 1'b1, 1'b1,
      '{ncs_pkg::SepReset, 1'b1, 1'b1, ncs_pkg::STAT_OK}},
    // stray close as a whole text
    '{ncs_pkg::ChClose, 8'h00, 1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, ncs_pkg::STAT_STRAY_CLOSE}},
    // unmatched open
    '{ncs_pkg::ChOpen, ChX, 1'b0, 1'b1, NoWant},
    '{ChX, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ncs_pkg::STAT_OPEN}},
    // special comment keeps its bytes and its semicolon
    '{ncs_pkg::ChOpen, ncs_pkg::ChAmp, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChAmp, ncs_pkg::ChSemi, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChSemi, ncs_pkg::ChClose, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChClose, ncs_pkg::ChSquote, 1'b0, 1'b0, NoWant},
    // quotes shield semicolons and brackets
    '{ncs_pkg::ChSquote, ncs_pkg::ChSemi, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChSemi, ncs_pkg::ChSquote, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChSquote, ncs_pkg::ChDquote, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChDquote, ncs_pkg::ChOpen, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChOpen, ncs_pkg::ChDquote, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChDquote, ncs_pkg::ChSemi, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChSemi, 8'h00, 1'b1, 1'b0, NoWant},
    // byte extremes and a zero byte
    '{8'hFF, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ncs_pkg::STAT_OK}},
    '{8'h00, 8'h01, 1'b0, 1'b0, NoWant},
    '{8'h01, 8'h00, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b1, ncs_pkg::STAT_OK}},
    // nested comments, open-amp inside a comment, then a stray close
    '{ncs_pkg::ChOpen, ncs_pkg::ChOpen, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChOpen, ncs_pkg::ChAmp, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChClose, 8'h61, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChClose, ncs_pkg::ChClose, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChClose, 8'h62, 1'b0, 1'b0, NoWant},
    '{8'h62, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ncs_pkg::STAT_STRAY_CLOSE}},
    // close while a standard comment is open inside a special one
    '{ncs_pkg::ChOpen, ncs_pkg::ChAmp, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChAmp, ncs_pkg::ChOpen, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChOpen, ncs_pkg::ChClose, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChClose, ncs_pkg::ChClose, 1'b0, 1'b0, NoWant},
    '{ncs_pkg::ChClose, 8'h00, 1'b1, 1'b0, NoWant}
  };

  // scanner: advance the state by one byte and return the cleaned result
  function automatic ncs_pkg::result_t strip_byte(logic [7:0] cur, logic [7:0] nxt,
                                                  logic last);
    ncs_pkg::result_t res;
    logic             in_comm;
    logic             keep;
    ncs_pkg::quote_e  qk;
    res = NoWant;
    if (err_q != ncs_pkg::ERR_CLOSE) begin
      in_comm = (depth_q != '0) || special_q;
      keep    = 1'b1;
      qk = (cur == ncs_pkg::ChSquote) ? ncs_pkg::QUOTE_SINGLE :
           (cur == ncs_pkg::ChDquote) ? ncs_pkg::QUOTE_DOUBLE : ncs_pkg::QUOTE_NONE;
      if (!in_comm && quote_q != ncs_pkg::QUOTE_NONE && qk == quote_q) begin
        quote_q = ncs_pkg::QUOTE_NONE;
      end else if (quote_q == ncs_pkg::QUOTE_NONE && !in_comm &&
                   qk != ncs_pkg::QUOTE_NONE) begin
        quote_q = qk;
      end else if (quote_q == ncs_pkg::QUOTE_NONE && cur == ncs_pkg::ChOpen) begin
        if (nxt == ncs_pkg::ChAmp && !in_comm) begin
          special_q = 1'b1;
        end else if (depth_q >= ncs_pkg::DepthW'(ncs_pkg::DepthMax)) begin
          depth_q = ncs_pkg::DepthW'(ncs_pkg::DepthMax);
          err_q   = ncs_pkg::ERR_OVER;
        end else begin
          depth_q = depth_q + ncs_pkg::DepthW'(1);
        end
      end else if (quote_q == ncs_pkg::QUOTE_NONE && cur == ncs_pkg::ChClose) begin
        if (special_q) begin
          special_q = 1'b0;
        end else if (depth_q == '0) begin
          err_q = ncs_pkg::ERR_CLOSE;
          keep  = 1'b0;
        end else begin
          depth_q = depth_q - ncs_pkg::DepthW'(1);
          keep    = 1'b0;
        end
      end
      if (keep && depth_q == '0) begin
        res.kept = 1'b1;
        if (cur == ncs_pkg::ChSemi && quote_q == ncs_pkg::QUOTE_NONE && !special_q)
          res.out_byte = sep_q;
        else res.out_byte = cur;
      end
    end
    res.final_res = last;
    if (last) begin
      if (err_q == ncs_pkg::ERR_CLOSE) res.status = ncs_pkg::STAT_STRAY_CLOSE;
      else if (err_q == ncs_pkg::ERR_OVER) res.status = ncs_pkg::STAT_OVERFLOW;
      else if (depth_q != '0) res.status = ncs_pkg::STAT_OPEN;
      else res.status = ncs_pkg::STAT_OK;
      quote_q   = ncs_pkg::QUOTE_NONE;
      depth_q   = '0;
      special_q = 1'b0;
      err_q     = ncs_pkg::ERR_NONE;
    end
    return res;
  endfunction

  // byte with a bias toward the characters the scanner cares about
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return ncs_pkg::ChSemi;
      1: return ncs_pkg::ChOpen;
      2: return ncs_pkg::ChClose;
      3: return ncs_pkg::ChAmp;
      4: return ncs_pkg::ChSquote;
      5: return ncs_pkg::ChDquote;
      6, 7, 8, 9: return 8'($urandom_range(8'h61, 8'h7A));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // send one request in bursts; predict on acceptance
  task automatic send_req(input logic [7:0] cur, input logic [7:0] nxt, input logic last,
                          input logic typed, input ncs_pkg::result_t want);
    ncs_pkg::result_t pred;
    int unsigned      gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i  = 1'b1;
    cur_byte_i  = cur;
    next_byte_i = nxt;
    is_last_i   = last;
    do @(posedge clk_i); while (in_stall_o);
    pred = strip_byte(cur, nxt, last);
    cleaned_q.push_back(typed ? want : pred);
    items_sent++;
    if (last) texts_sent++;
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
  endtask

  // whole text, lookahead taken from the text itself
  task automatic send_text(input logic [7:0] txt [$]);
    for (int i = 0; i < txt.size(); i++) begin
      send_req(txt[i], (i + 1 < txt.size()) ? txt[i + 1] : 8'h00, i == txt.size() - 1,
               1'b0, NoWant);
    end
  endtask

  // hold off requests until every result is back, plus the pipeline depth
  task automatic drain();
    in_valid_i = 1'b0;
    while (cleaned_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_separator(input logic [7:0] value);
    drain();
    sep_wr_en_i   = 1'b1;
    sep_wr_data_i = value;
    @(negedge clk_i);
    sep_wr_en_i = 1'b0;
    sep_q       = value;
  endtask

  // result side stall, changing style after each random span
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_span = $urandom_range(30, 90);
    end
    stall_span--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     res_stall_i = 1'b0;
      STALL_RANDOM:   res_stall_i = ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: res_stall_i = ((stall_phase % 5) < 2);
      default: begin
        if (stall_run == 0) begin
          stall_run  = $urandom_range(1, 12);
          stall_hold = ~stall_hold;
        end
        stall_run--;
        res_stall_i = stall_hold;
      end
    endcase
  end

  // result checker and watchdog
  always @(posedge clk_i) begin : check_results
    ncs_pkg::result_t got;
    ncs_pkg::result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (res_valid_o && !res_stall_i) begin
        got = '{out_byte_o, out_valid_o, final_res_o, ncs_pkg::status_e'(status_o)};
        results_seen++;
        if (out_valid_o) kept_seen++;
        if (final_res_o) status_seen[status_o]++;
        if (cleaned_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: byte %h kept %b final %b status %0d",
                     got.out_byte, got.kept, got.final_res, got.status);
        end else begin
          want = cleaned_q.pop_front();
          if (got.out_byte !== want.out_byte || got.kept !== want.kept ||
              got.final_res !== want.final_res || got.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch at result %0d: want byte %h kept %b final %b status %0d,",
                        " got byte %h kept %b final %b status %0d"},
                       results_seen, want.out_byte, want.kept, want.final_res, want.status,
                       got.out_byte, got.kept, got.final_res, got.status);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [7:0]  txt [$];
    logic [7:0]  q;
    logic [7:0]  sep_list [5];
    int unsigned d;
    int unsigned len;
    int unsigned r;
    int unsigned chunk_end;
    logic        last;
    sep_list = '{8'h00, 8'hFF, ncs_pkg::ChSemi, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255))};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < 30; i++) begin
      send_req(dir_tab[i].cur, dir_tab[i].nxt, dir_tab[i].last, dir_tab[i].typed,
               dir_tab[i].want);
    end

    // depth up to the limit, then one open past it
    write_separator(8'h00);
    txt.delete();
    repeat (ncs_pkg::DepthMax + 1) txt.push_back(ncs_pkg::ChOpen);
    txt.push_back(ChX);
    txt.push_back(ncs_pkg::ChClose);
    txt.push_back(ncs_pkg::ChSemi);
    send_text(txt);

    // random texts in chunks, one separator setting per chunk
    for (int c = 0; c < 5; c++) begin
      write_separator(sep_list[c]);
      gaps_on   = (c != 2);
      chunk_end = items_sent + 40;
      while (items_sent < chunk_end) begin
        if ($urandom_range(0, 99) < 85) begin
          // mostly balanced text with random content
          txt.delete();
          d   = 0;
          len = $urandom_range(1, 24);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
              txt.push_back(ncs_pkg::ChOpen);
              d++;
            end else if (r < 16) begin
              txt.push_back(ncs_pkg::ChOpen);
              txt.push_back(ncs_pkg::ChAmp);
              d++;
            end else if (r < 26 && d > 0) begin
              txt.push_back(ncs_pkg::ChClose);
              d--;
            end else if (r < 34) begin
              q = r[0] ? ncs_pkg::ChSquote : ncs_pkg::ChDquote;
              txt.push_back(q);
              txt.push_back(pick_char());
              txt.push_back(q);
            end else begin
              txt.push_back(pick_char());
            end
          end
          r = $urandom_range(0, 9);
          if (r > 1) repeat (d) txt.push_back(ncs_pkg::ChClose);
          else if (r == 1) txt.push_back(ncs_pkg::ChClose);
          send_text(txt);
        end else begin
          // raw noise: lookahead and end flag unrelated to the bytes
          len = $urandom_range(3, 10);
          for (int i = 0; i < len; i++) begin
            last = (i == len - 1) || ($urandom_range(0, 7) == 0);
            send_req($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(1, 255)),
                     $urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)),
                     last, 1'b0, NoWant);
          end
        end
      end
    end

    // pipeline drain and final verdict
    drain();
    $display("covered %0d requests in %0d texts, %0d kept bytes, 5 separator settings",
             items_sent, texts_sent, kept_seen);
    $display("final status ok/close/open/overflow: %0d/%0d/%0d/%0d, %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], fail_count);
    if (fail_count == 0 && cleaned_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
